// ===== src/tht_pkg.sv =====
package tht_pkg;

	localparam int OP_W       = 3;
	localparam int SEQ_W      = 32;
	localparam int TIME_W     = 32;
	localparam int STATE_W    = 3;
	localparam int OUT_CNT_W  = 16;
	localparam int TIMEOUT_W  = 16;
	localparam int CNT_BITS_DEF = 16;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd60;

	typedef enum logic [OP_W-1:0] {
		OP_OPEN   = 3'd0,
		OP_SYN    = 3'd1,
		OP_SYNACK = 3'd2,
		OP_ACK    = 3'd3,
		OP_RST    = 3'd4,
		OP_TICK   = 3'd5
	} op_t;

	typedef enum logic [STATE_W-1:0] {
		ST_CLOSED      = 3'd0,
		ST_LISTEN      = 3'd1,
		ST_SYN_SENT    = 3'd2,
		ST_SYN_RECV    = 3'd3,
		ST_ESTABLISHED = 3'd4
	} side_state_t;

endpackage

// ===== src/tht_in_if.sv =====
interface tht_in_if;
	import tht_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic                from_initiator;
	logic [SEQ_W-1:0]    seq_number;
	logic [SEQ_W-1:0]    ack_number;
	logic [TIME_W-1:0]   now_seconds;

	modport source (
		output valid, op, from_initiator, seq_number, ack_number, now_seconds,
		input  ready
	);

	modport sink (
		input  valid, op, from_initiator, seq_number, ack_number, now_seconds,
		output ready
	);

endinterface

// ===== src/tht_out_if.sv =====
interface tht_out_if;
	import tht_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 status;
	logic [STATE_W-1:0]   initiator_state;
	logic [STATE_W-1:0]   responder_state;
	logic                 established;
	logic                 closed;
	logic                 timed_out;
	logic [OUT_CNT_W-1:0] dup_syn_count;
	logic [OUT_CNT_W-1:0] dup_synack_count;
	logic [OUT_CNT_W-1:0] reset_count;

	modport source (
		output valid, status, initiator_state, responder_state, established, closed,
		       timed_out, dup_syn_count, dup_synack_count, reset_count,
		input  ready
	);

	modport sink (
		input  valid, status, initiator_state, responder_state, established, closed,
		       timed_out, dup_syn_count, dup_synack_count, reset_count,
		output ready
	);

endinterface

// ===== src/tcp_handshake_tracker_unit.sv =====
// tcp handshake tracker for one observed connection
//
// in_ch takes one segment event per transfer (open, syn, synack, ack, rst or
// tick) with its direction, seq/ack numbers and time. out_ch returns one
// result per event: accept/error status, both side states, established and
// closed flags, idle timeout flag and the three saturating tallies.
// cfg_we/cfg_data write the idle timeout in seconds (reset value 60).
//
// pipeline: two register stages (input register, then state update into the
// result register).
// throughput: one event per cycle while out_ch does not stall; the state
// update loop through the session registers sets that figure.
//
// reset clears the session state, the tallies and both valid flags and
// reloads the timeout. when out_ch stalls, the finished result holds and
// one more event is taken into the input register; after that in_ch.ready
// drops until the result is taken.
module tcp_handshake_tracker_unit #(
	parameter int COUNTER_BITS = tht_pkg::CNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tht_pkg::TIMEOUT_W-1:0]  cfg_data,
	tht_in_if.sink                         in_ch,
	tht_out_if.source                      out_ch
);
	import tht_pkg::*;

	// input register
	logic               valid_s1;
	logic [OP_W-1:0]    op_s1;
	logic               from_init_s1;
	logic [SEQ_W-1:0]   seq_s1;
	logic [SEQ_W-1:0]   ack_s1;
	logic [TIME_W-1:0]  now_s1;

	// session state
	side_state_t             side_q      [2];
	logic [SEQ_W-1:0]        first_seq_q [2];
	logic [SEQ_W-1:0]        last_seq_q  [2];
	logic [SEQ_W-1:0]        first_ack_q [2];
	logic [SEQ_W-1:0]        last_ack_q  [2];
	logic [TIME_W-1:0]       last_seen_q;
	logic [COUNTER_BITS-1:0] dup_syn_q;
	logic [COUNTER_BITS-1:0] dup_synack_q;
	logic [COUNTER_BITS-1:0] rst_cnt_q;
	logic [TIMEOUT_W-1:0]    timeout_q;

	// next state
	side_state_t             side_d      [2];
	logic [SEQ_W-1:0]        first_seq_d [2];
	logic [SEQ_W-1:0]        last_seq_d  [2];
	logic [SEQ_W-1:0]        first_ack_d [2];
	logic [SEQ_W-1:0]        last_ack_d  [2];
	logic [TIME_W-1:0]       last_seen_d;
	logic [COUNTER_BITS-1:0] dup_syn_d;
	logic [COUNTER_BITS-1:0] dup_synack_d;
	logic [COUNTER_BITS-1:0] rst_cnt_d;
	logic                    err;
	logic                    timed_out_d;

	logic               out_valid_q;
	logic               advance;
	logic               self_i;
	logic               peer_i;
	logic [SEQ_W-1:0]   peer_next;
	logic [TIME_W-1:0]  elapsed;

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	assign self_i    = ~from_init_s1;
	assign peer_i    = from_init_s1;
	assign peer_next = last_seq_q[peer_i] + SEQ_W'(1);

	always_comb begin
		side_d       = side_q;
		first_seq_d  = first_seq_q;
		last_seq_d   = last_seq_q;
		first_ack_d  = first_ack_q;
		last_ack_d   = last_ack_q;
		last_seen_d  = last_seen_q;
		dup_syn_d    = dup_syn_q;
		dup_synack_d = dup_synack_q;
		rst_cnt_d    = rst_cnt_q;
		err          = 1'b0;

		case (op_t'(op_s1))
			OP_OPEN: begin
				side_d       = '{ST_CLOSED, ST_CLOSED};
				first_seq_d  = '{'0, '0};
				last_seq_d   = '{'0, '0};
				first_ack_d  = '{'0, '0};
				last_ack_d   = '{'0, '0};
				last_seen_d  = now_s1;
				dup_syn_d    = '0;
				dup_synack_d = '0;
				rst_cnt_d    = '0;
			end
			OP_SYN: begin
				last_seen_d = now_s1;
				case (side_q[self_i])
					ST_CLOSED: begin
						side_d[self_i]      = ST_SYN_SENT;
						side_d[peer_i]      = ST_LISTEN;
						first_seq_d[self_i] = seq_s1;
						last_seq_d[self_i]  = seq_s1;
						first_ack_d[self_i] = ack_s1;
						last_ack_d[self_i]  = ack_s1;
					end
					ST_LISTEN: begin
						if (ack_s1 != peer_next) begin
							err = 1'b1;
						end else begin
							side_d[self_i]      = ST_SYN_SENT;
							first_seq_d[self_i] = seq_s1;
							last_seq_d[self_i]  = seq_s1;
							first_ack_d[self_i] = ack_s1;
							last_ack_d[self_i]  = ack_s1;
						end
					end
					ST_SYN_SENT: begin
						if (seq_s1 == first_seq_q[self_i] && ack_s1 == first_ack_q[self_i]) begin
							if (dup_syn_q != '1)
								dup_syn_d = dup_syn_q + COUNTER_BITS'(1);
						end else begin
							err = 1'b1;
						end
					end
					default: err = 1'b1;
				endcase
			end
			OP_SYNACK: begin
				last_seen_d = now_s1;
				case (side_q[self_i])
					ST_LISTEN: begin
						if (ack_s1 != peer_next) begin
							err = 1'b1;
						end else begin
							side_d[self_i]      = ST_SYN_RECV;
							first_seq_d[self_i] = seq_s1;
							last_seq_d[self_i]  = seq_s1;
							first_ack_d[self_i] = ack_s1;
							last_ack_d[self_i]  = ack_s1;
						end
					end
					ST_SYN_SENT: begin
						if (seq_s1 == last_seq_q[self_i] && ack_s1 == peer_next) begin
							side_d[self_i]     = ST_SYN_RECV;
							last_ack_d[self_i] = ack_s1;
						end else begin
							err = 1'b1;
						end
					end
					ST_SYN_RECV: begin
						if (seq_s1 == last_seq_q[self_i] && ack_s1 == last_ack_q[self_i]) begin
							if (dup_synack_q != '1)
								dup_synack_d = dup_synack_q + COUNTER_BITS'(1);
						end else begin
							err = 1'b1;
						end
					end
					default: err = 1'b1;
				endcase
			end
			OP_ACK: begin
				last_seen_d = now_s1;
				// the match conditions reject here, accepting everything else
				case (side_q[self_i])
					ST_SYN_SENT: begin
						if (seq_s1 == last_seq_q[self_i] && ack_s1 == peer_next) begin
							err = 1'b1;
						end else begin
							side_d             = '{ST_ESTABLISHED, ST_ESTABLISHED};
							last_ack_d[self_i] = ack_s1;
						end
					end
					ST_SYN_RECV: begin
						if (seq_s1 == last_seq_q[self_i] + SEQ_W'(1) && ack_s1 == peer_next) begin
							err = 1'b1;
						end else begin
							side_d             = '{ST_ESTABLISHED, ST_ESTABLISHED};
							last_seq_d[self_i] = seq_s1;
							last_ack_d[self_i] = ack_s1;
						end
					end
					ST_ESTABLISHED: err = 1'b0;
					default:        err = 1'b1;
				endcase
			end
			OP_RST: begin
				last_seen_d = now_s1;
				side_d      = '{ST_CLOSED, ST_CLOSED};
				if (rst_cnt_q != '1)
					rst_cnt_d = rst_cnt_q + COUNTER_BITS'(1);
			end
			default: err = 1'b0;
		endcase
	end

	assign elapsed     = now_s1 - last_seen_d;
	assign timed_out_d = (now_s1 >= last_seen_d) &&
		(elapsed >= TIME_W'(timeout_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			op_s1        <= in_ch.op;
			from_init_s1 <= in_ch.from_initiator;
			seq_s1       <= in_ch.seq_number;
			ack_s1       <= in_ch.ack_number;
			now_s1       <= in_ch.now_seconds;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q       <= '{ST_CLOSED, ST_CLOSED};
			first_seq_q  <= '{'0, '0};
			last_seq_q   <= '{'0, '0};
			first_ack_q  <= '{'0, '0};
			last_ack_q   <= '{'0, '0};
			last_seen_q  <= '0;
			dup_syn_q    <= '0;
			dup_synack_q <= '0;
			rst_cnt_q    <= '0;
		end else if (advance) begin
			side_q       <= side_d;
			first_seq_q  <= first_seq_d;
			last_seq_q   <= last_seq_d;
			first_ack_q  <= first_ack_d;
			last_ack_q   <= last_ack_d;
			last_seen_q  <= last_seen_d;
			dup_syn_q    <= dup_syn_d;
			dup_synack_q <= dup_synack_d;
			rst_cnt_q    <= rst_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance) begin
			out_ch.status           <= err;
			out_ch.initiator_state  <= side_d[0];
			out_ch.responder_state  <= side_d[1];
			out_ch.established      <= (side_d[0] == ST_ESTABLISHED) &&
				(side_d[1] == ST_ESTABLISHED);
			out_ch.closed           <= (side_d[0] == ST_CLOSED) && (side_d[1] == ST_CLOSED);
			out_ch.timed_out        <= timed_out_d;
			out_ch.dup_syn_count    <= OUT_CNT_W'(dup_syn_d);
			out_ch.dup_synack_count <= OUT_CNT_W'(dup_synack_d);
			out_ch.reset_count      <= OUT_CNT_W'(rst_cnt_d);
		end
	end

	assign out_ch.valid = out_valid_q;

`ifndef SYNTH
	// with no result pending, the input register is always ready to take an item
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ch.ready)
		else $error("input stalled with no result pending");

	a_rst_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && op_s1 == OP_RST) |=> (out_ch.closed && !out_ch.status))
		else $error("rst did not close both sides");

	a_rst_tally_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && op_s1 != OP_OPEN) |=> (rst_cnt_q >= $past(rst_cnt_q)))
		else $error("rst tally went down without open");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_ch.established && out_ch.closed))
		else $error("established and closed both set");

	a_segment_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (op_s1 == OP_SYN || op_s1 == OP_ACK || op_s1 == OP_RST))
		|=> (out_ch.timed_out == ($past(timeout_q) == '0)))
		else $error("segment event timeout flag wrong");
`endif

endmodule
